FILE: hdl/mrps_pkg.sv
`default_nettype none
package mrps_pkg;

    // Sizing
    localparam int QUEUE_DEPTH  = 4;
    localparam int PAYLOAD_BITS = 32;
    localparam int NPORTS       = 4;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Command codes
    localparam logic [1:0] OP_ARRIVE = 2'd0;
    localparam logic [1:0] OP_END    = 2'd1;
    localparam logic [1:0] OP_SHIFT  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_ACCEPT  = 2'd0;
    localparam logic [1:0] KIND_DROP    = 2'd1;
    localparam logic [1:0] KIND_DELIVER = 2'd2;

    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] data;
        logic [NPORTS-1:0]       mask;
    } t_pkt;

    typedef struct packed {
        logic busy;
        t_pkt pkt;
    } t_slot;

    // Per-cell command from the top level
    typedef struct packed {
        logic              arrive;
        logic              load;
        logic              shift;
        logic [31:0]       payload;
        logic [NPORTS-1:0] mask;
    } t_cmd;

    // Pending delivery held in a cell
    typedef struct packed {
        logic valid;
        t_pkt pkt;
    } t_deliv;

    function automatic logic [PAYLOAD_BITS-1:0] fit_in(input logic [31:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[PAYLOAD_BITS-1:0];
    endfunction

    function automatic logic [31:0] fit_out(input logic [PAYLOAD_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

endpackage
`default_nettype wire

FILE: hdl/mrps_cell.sv
`default_nettype none
module mrps_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [mrps_pkg::NPORTS-1:0]   i_own,
    input  wire mrps_pkg::t_cmd                i_cmd,
    input  wire logic                          i_clear,
    input  wire mrps_pkg::t_slot               i_next,
    output mrps_pkg::t_slot                    o_loaded,
    output logic                               o_full,
    output mrps_pkg::t_deliv                   o_pend
);

    mrps_pkg::t_pkt               r_q [mrps_pkg::QUEUE_DEPTH];
    logic [mrps_pkg::QW-1:0]      r_head, n_head;
    logic [mrps_pkg::CW-1:0]      r_count, n_count;
    mrps_pkg::t_slot              r_slot, n_slot;
    mrps_pkg::t_deliv             r_pend, n_pend;
    logic                         ld;
    logic                         we;
    logic [mrps_pkg::CW:0]        sum;
    logic [mrps_pkg::QW-1:0]      tail;
    mrps_pkg::t_pkt               wr_pkt;

    assign o_full = (r_count == mrps_pkg::CW'(mrps_pkg::QUEUE_DEPTH));
    assign o_pend = r_pend;

    // Tail position, wrapped
    always_comb begin
        sum = {1'b0, r_count} + (mrps_pkg::CW + 1)'(r_head);
        if (sum >= (mrps_pkg::CW + 1)'(mrps_pkg::QUEUE_DEPTH)) begin
            sum = sum - (mrps_pkg::CW + 1)'(mrps_pkg::QUEUE_DEPTH);
        end
        tail = sum[mrps_pkg::QW-1:0];
    end

    // Free slot takes the queue head on a cycle end or a shift
    assign ld = i_cmd.load && !r_slot.busy && (r_count != '0);

    always_comb begin
        o_loaded = r_slot;
        if (ld) begin
            o_loaded.busy = 1'b1;
            o_loaded.pkt  = r_q[r_head];
        end
    end

    assign we          = i_cmd.arrive && !o_full;
    assign wr_pkt.data = mrps_pkg::fit_in(i_cmd.payload);
    assign wr_pkt.mask = i_cmd.mask;

    // Queue pointers, slot rotation and delivery
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_slot  = r_slot;
        n_pend  = r_pend;
        if (i_clear) begin
            n_pend.valid = 1'b0;
        end
        if (we) begin
            n_count = r_count + 1'b1;
        end
        if (ld) begin
            n_count = r_count - 1'b1;
            n_head  = (r_head == mrps_pkg::QW'(mrps_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : r_head + 1'b1;
        end
        if (i_cmd.load) begin
            n_slot = i_cmd.shift ? i_next : o_loaded;
        end
        if (i_cmd.shift && n_slot.busy && ((n_slot.pkt.mask & i_own) != '0)) begin
            n_pend.valid      = 1'b1;
            n_pend.pkt        = n_slot.pkt;
            n_slot.pkt.mask   = n_slot.pkt.mask & ~i_own;
            if (n_slot.pkt.mask == '0) begin
                n_slot.busy = 1'b0;
            end
        end
    end

    // Queue storage, no reset
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_q[tail] <= wr_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot.pkt <= n_slot.pkt;
        r_pend.pkt <= n_pend.pkt;
        if (!i_rst_n) begin
            r_head       <= '0;
            r_count      <= '0;
            r_slot.busy  <= 1'b0;
            r_pend.valid <= 1'b0;
        end else begin
            r_head       <= n_head;
            r_count      <= n_count;
            r_slot.busy  <= n_slot.busy;
            r_pend.valid <= n_pend.valid;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/multicast_ring_packet_switch.sv
`default_nettype none
// Arrival: accept/drop result strobed in the cycle after the start transfer.
// Cycle end without deliveries: next start taken at once.
// Shift with n deliveries: each copy goes from a cell's pending register to the
// result register, one per cycle in port order; busy stays high, and no start is
// taken, until the single result port has drained the cells' pending copies.
// Reset (i_rst_n low, synchronous) empties all queues and frees all ring slots.
module multicast_ring_packet_switch (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_op,
    input  wire logic [1:0]                  i_port,
    input  wire logic [31:0]                 i_payload,
    input  wire logic [3:0]                  i_dest_mask,
    output logic                             o_valid,
    output logic [1:0]                       o_kind,
    output logic [1:0]                       o_out_port,
    output logic [31:0]                      o_out_payload,
    output logic [3:0]                       o_out_mask,
    output logic                             o_last
);

    localparam int NP = mrps_pkg::NPORTS;

    mrps_pkg::t_cmd    cmd    [NP];
    mrps_pkg::t_slot   loaded [NP];
    mrps_pkg::t_deliv  pend   [NP];
    logic [NP-1:0]     full;
    logic [NP-1:0]     pend_v;
    logic [NP-1:0]     clear;
    logic [1:0]        sel;
    logic              acc;

    logic              r_valid;
    logic [1:0]        r_kind;
    logic [1:0]        r_port;
    logic [31:0]       r_payload;
    logic [3:0]        r_mask;
    logic              r_last;

    assign acc  = start && !busy;
    assign busy = |pend_v;

    // Ring of cells, each shifting from its upper neighbor
    for (genvar g = 0; g < NP; g++) begin : g_cell
        assign cmd[g].arrive  = acc && (i_op == mrps_pkg::OP_ARRIVE) && (i_port == 2'(g));
        assign cmd[g].load    = acc && ((i_op == mrps_pkg::OP_END) ||
                                        (i_op == mrps_pkg::OP_SHIFT));
        assign cmd[g].shift   = acc && (i_op == mrps_pkg::OP_SHIFT);
        assign cmd[g].payload = i_payload;
        assign cmd[g].mask    = i_dest_mask;
        assign pend_v[g]      = pend[g].valid;

        mrps_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_own    (NP'(1) << g),
            .i_cmd    (cmd[g]),
            .i_clear  (clear[g]),
            .i_next   (loaded[(g + 1) % NP]),
            .o_loaded (loaded[g]),
            .o_full   (full[g]),
            .o_pend   (pend[g])
        );
    end

    // Lowest pending port goes out first
    always_comb begin
        sel = '0;
        for (int k = NP - 1; k >= 0; k--) begin
            if (pend_v[k]) begin
                sel = 2'(k);
            end
        end
        clear = pend_v & (NP'(1) << sel);
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (busy) begin
                r_valid   <= 1'b1;
                r_kind    <= mrps_pkg::KIND_DELIVER;
                r_port    <= sel;
                r_payload <= mrps_pkg::fit_out(pend[sel].pkt.data);
                r_mask    <= pend[sel].pkt.mask;
                r_last    <= ((pend_v & ~clear) == '0);
            end else if (acc && (i_op == mrps_pkg::OP_ARRIVE)) begin
                r_valid   <= 1'b1;
                r_kind    <= full[i_port] ? mrps_pkg::KIND_DROP : mrps_pkg::KIND_ACCEPT;
                r_port    <= i_port;
                r_payload <= '0;
                r_mask    <= '0;
                r_last    <= 1'b1;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_out_port    = r_port;
    assign o_out_payload = r_payload;
    assign o_out_mask    = r_mask;
    assign o_last        = r_last;

`ifndef SYNTHESIS
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("pending delivery not strobed out");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("last result while deliveries remain");
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("non-final result with nothing pending");
    a_arrival_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind != mrps_pkg::KIND_DELIVER)) |-> o_last)
        else $error("arrival result not final");
`endif

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Op value three has no name in the package; the block must ignore it
    localparam logic [1:0] OP_IGNORED  = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         TAIL_CYCLES = 20;
    localparam int         RAND_ITEMS  = 450;
    localparam logic [63:0] DATA_KEEP  = (64'd1 << mrps_pkg::PAYLOAD_BITS) - 64'd1;

    typedef struct {
        logic [1:0]  op;
        logic [1:0]  port;
        logic [31:0] payload;
        logic [3:0]  mask;
        int unsigned gap;
    } t_tb_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  port;
        logic [31:0] payload;
        logic [3:0]  mask;
        logic        last;
    } t_switch_event;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic [1:0]  i_op        = mrps_pkg::OP_END;
    logic [1:0]  i_port      = 2'd0;
    logic [31:0] i_payload   = 32'd0;
    logic [3:0]  i_dest_mask = 4'd0;
    logic        busy;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [1:0]  o_out_port;
    logic [31:0] o_out_payload;
    logic [3:0]  o_out_mask;
    logic        o_last;

    multicast_ring_packet_switch dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_port        (i_port),
        .i_payload     (i_payload),
        .i_dest_mask   (i_dest_mask),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_out_port    (o_out_port),
        .o_out_payload (o_out_payload),
        .o_out_mask    (o_out_mask),
        .o_last        (o_last)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Switch state as the testbench sees it
    logic [31:0]     inq_data  [mrps_pkg::NPORTS][mrps_pkg::QUEUE_DEPTH];
    logic [3:0]      inq_mask  [mrps_pkg::NPORTS][mrps_pkg::QUEUE_DEPTH];
    int unsigned     inq_head  [mrps_pkg::NPORTS];
    int unsigned     inq_count [mrps_pkg::NPORTS];
    logic [31:0]     ring_data [mrps_pkg::NPORTS];
    logic [3:0]      ring_mask [mrps_pkg::NPORTS];
    logic            ring_busy [mrps_pkg::NPORTS];

    t_tb_cmd         pending_cmds[$];
    t_switch_event   due_events[$];
    int unsigned     mismatches = 0;
    int unsigned     cycle_count = 0;
    int unsigned     gap_left = 0;
    int unsigned     zero_masks = 0;

    initial begin
        for (int p = 0; p < mrps_pkg::NPORTS; p++) begin
            inq_head[p]  = 0;
            inq_count[p] = 0;
            ring_busy[p] = 1'b0;
            ring_data[p] = '0;
            ring_mask[p] = '0;
        end
    end

    // Work out the events one accepted command causes and queue them
    task automatic advance_switch(input logic [1:0] op, input logic [1:0] port,
                                  input logic [31:0] payload, input logic [3:0] mask);
        int unsigned     tail;
        int              n;
        logic [63:0]     wide;
        logic [31:0]     d0;
        logic [3:0]      m0;
        logic            b0;
        t_switch_event   ev;
        n = 0;
        if (op == OP_IGNORED)
            return;
        if (op == mrps_pkg::OP_ARRIVE) begin
            ev = '{kind: mrps_pkg::KIND_ACCEPT, port: port, payload: '0, mask: '0,
                   last: 1'b1};
            if (inq_count[port] >= mrps_pkg::QUEUE_DEPTH) begin
                ev.kind = mrps_pkg::KIND_DROP;
            end else begin
                tail = (inq_head[port] + inq_count[port]) % mrps_pkg::QUEUE_DEPTH;
                wide = {32'd0, payload} & DATA_KEEP;
                inq_data[port][tail] = wide[31:0];
                inq_mask[port][tail] = mask;
                inq_count[port]++;
            end
            due_events.push_back(ev);
            return;
        end
        // free slots load their port's queue head
        for (int i = 0; i < mrps_pkg::NPORTS; i++) begin
            if (!ring_busy[i] && inq_count[i] > 0) begin
                ring_data[i] = inq_data[i][inq_head[i]];
                ring_mask[i] = inq_mask[i][inq_head[i]];
                inq_head[i]  = (inq_head[i] + 1) % mrps_pkg::QUEUE_DEPTH;
                inq_count[i]--;
                ring_busy[i] = 1'b1;
            end
        end
        if (op != mrps_pkg::OP_SHIFT)
            return;
        // rotate: slot i takes slot i+1, slot 3 takes slot 0
        d0 = ring_data[0];
        m0 = ring_mask[0];
        b0 = ring_busy[0];
        for (int i = 0; i < mrps_pkg::NPORTS - 1; i++) begin
            ring_data[i] = ring_data[i+1];
            ring_mask[i] = ring_mask[i+1];
            ring_busy[i] = ring_busy[i+1];
        end
        ring_data[mrps_pkg::NPORTS-1] = d0;
        ring_mask[mrps_pkg::NPORTS-1] = m0;
        ring_busy[mrps_pkg::NPORTS-1] = b0;
        // deliveries in port order
        for (int i = 0; i < mrps_pkg::NPORTS; i++) begin
            if (ring_busy[i] && ring_mask[i][i]) begin
                ev = '{kind: mrps_pkg::KIND_DELIVER, port: 2'(i), payload: ring_data[i],
                       mask: ring_mask[i], last: 1'b0};
                due_events.push_back(ev);
                n++;
                ring_mask[i][i] = 1'b0;
                if (ring_mask[i] == 4'd0)
                    ring_busy[i] = 1'b0;
            end
        end
        if (n > 0)
            due_events[due_events.size()-1].last = 1'b1;
    endtask

    task automatic add_cmd(input logic [1:0] op, input logic [1:0] port,
                           input logic [31:0] payload, input logic [3:0] mask,
                           input int unsigned gap);
        t_tb_cmd c;
        c = '{op: op, port: port, payload: payload, mask: mask, gap: gap};
        pending_cmds.push_back(c);
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Driver: hold a command until its transfer, then idle or present the next
    always @(posedge i_clk) begin
        t_tb_cmd c;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else begin
            if (start)
                advance_switch(i_op, i_port, i_payload, i_dest_mask);
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds.pop_front();
                i_op        <= c.op;
                i_port      <= c.port;
                i_payload   <= c.payload;
                i_dest_mask <= c.mask;
                gap_left    = c.gap;
                start       <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic note_mismatch(input string what, input t_switch_event want,
                                 input t_switch_event got);
        mismatches++;
        if (mismatches <= 10) begin
            $write("[%0t] %s: expected kind=%0d port=%0d payload=%h mask=%h last=%0d,",
                   $realtime, what, want.kind, want.port, want.payload, want.mask,
                   want.last);
            $display(" got kind=%0d port=%0d payload=%h mask=%h last=%0d",
                     got.kind, got.port, got.payload, got.mask, got.last);
        end
    endtask

    // Monitor: every strobed result must match the oldest expected event
    always @(posedge i_clk) begin
        t_switch_event got;
        t_switch_event want;
        if (i_rst_n && o_valid) begin
            got = '{kind: o_kind, port: o_out_port, payload: o_out_payload,
                    mask: o_out_mask, last: o_last};
            if (due_events.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                want = due_events.pop_front();
                if (got != want)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        int unsigned arrive_pct;
        bit          no_idle;
        int unsigned r;
        logic [1:0]  op;
        logic [3:0]  mask;

        // directed: extremes, each op, drops, ignored op, empty mask
        add_cmd(mrps_pkg::OP_ARRIVE, 2'd0, 32'hFFFF_FFFF, 4'hF, 0);
        add_cmd(mrps_pkg::OP_ARRIVE, 2'd3, 32'h0000_0000, 4'h1, 0);
        add_cmd(mrps_pkg::OP_ARRIVE, 2'd1, 32'hA5A5_A5A5, 4'h2, 2);
        add_cmd(mrps_pkg::OP_END,    2'd0, 32'd0, 4'h0, 0);
        for (int k = 0; k < 4; k++)
            add_cmd(mrps_pkg::OP_SHIFT, 2'(k), 32'd0, 4'h0, k);
        add_cmd(OP_IGNORED, 2'd3, 32'hFFFF_FFFF, 4'hF, 0);
        // fifth arrival on a full queue is dropped
        for (int k = 0; k < 5; k++)
            add_cmd(mrps_pkg::OP_ARRIVE, 2'd1, 32'h1234_5670 + k, 4'h8, 0);
        // empty mask keeps circling
        add_cmd(mrps_pkg::OP_ARRIVE, 2'd2, 32'h5A5A_5A5A, 4'h0, 0);
        zero_masks = 1;
        for (int k = 0; k < 6; k++)
            add_cmd(mrps_pkg::OP_SHIFT, 2'd0, 32'd0, 4'h0, 0);

        // random: phases with different arrival pressure and idling
        arrive_pct = 50;
        no_idle    = 1'b0;
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k % 50 == 0) begin
                r = $urandom_range(0, 2);
                arrive_pct = (r == 0) ? 25 : (r == 1) ? 50 : 75;
                no_idle    = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 3)
                op = OP_IGNORED;
            else if (r < 3 + arrive_pct)
                op = mrps_pkg::OP_ARRIVE;
            else
                op = ($urandom_range(0, 9) < 7) ? mrps_pkg::OP_SHIFT : mrps_pkg::OP_END;
            // a zero mask occupies a slot for good, so keep it rare
            if (zero_masks < 2 && $urandom_range(0, 299) == 0) begin
                mask = 4'h0;
                zero_masks++;
            end else begin
                mask = 4'($urandom_range(1, 15));
            end
            add_cmd(op, 2'($urandom_range(0, 3)), $urandom, mask,
                    no_idle ? 0 : pick_gap());
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start || due_events.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && due_events.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
